// File: rtl/ser_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sensor extremes reporter package
// Shared constants, payload structs and cell link types.
// ----------------------------------------------------------------------------
package ser_pkg;

    localparam int SENSOR_COUNT_DEF   = 8;
    localparam int RANK_COUNT_DEF     = 5;
    localparam int INTERVAL_COUNT_DEF = 6;
    localparam int READING_W          = 8;
    localparam logic [7:0] MPI_RESET  = 8'd10;

    // Record kind codes.
    localparam logic KIND_RANK   = 1'b0;
    localparam logic KIND_WIDEST = 1'b1;

    typedef struct packed {
        logic signed [7:0] reading_0;
        logic signed [7:0] reading_1;
        logic signed [7:0] reading_2;
        logic signed [7:0] reading_3;
        logic signed [7:0] reading_4;
        logic signed [7:0] reading_5;
        logic signed [7:0] reading_6;
        logic signed [7:0] reading_7;
    } ser_in_t;

    typedef struct packed {
        logic              record_kind;
        logic [2:0]        rank;
        logic signed [7:0] high_reading;
        logic signed [7:0] low_reading;
        logic [2:0]        widest_interval;
        logic [7:0]        widest_spread;
        logic              last_of_report;
    } ser_out_t;

    // State a cell shows to its right-hand neighbor.
    typedef struct packed {
        logic              valid;
        logic signed [7:0] hi;
        logic signed [7:0] lo;
        logic              take_hi;
        logic              take_lo;
    } ser_link_t;

    // Report values a cell hands to its left-hand neighbor.
    typedef struct packed {
        logic signed [7:0] hi;
        logic signed [7:0] lo;
    } ser_rep_t;

    // Broadcast control for the row of rank cells.
    typedef struct packed {
        logic              insert;
        logic              snap;
        logic              shift;
        logic signed [7:0] new_hi;
        logic signed [7:0] new_lo;
    } ser_ctrl_t;

endpackage
`default_nettype wire

// File: rtl/ser_minmax.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Minute extremes stage
// Registers one minute's maximum and minimum reading and holds it until
// the downstream logic takes it.
// ----------------------------------------------------------------------------
module ser_minmax
    import ser_pkg::*;
#(
    parameter int SENSOR_COUNT = SENSOR_COUNT_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire ser_in_t           s_data,
    input  wire logic              take,
    output logic                   st_valid,
    output logic signed [7:0]      st_max,
    output logic signed [7:0]      st_min
);

    logic              valid_reg;
    logic signed [7:0] max_reg;
    logic signed [7:0] min_reg;
    logic signed [7:0] max_next;
    logic signed [7:0] min_next;
    logic signed [7:0] rd [8];

    // Readings in sensor order.
    always_comb begin
        rd[0] = s_data.reading_0;
        rd[1] = s_data.reading_1;
        rd[2] = s_data.reading_2;
        rd[3] = s_data.reading_3;
        rd[4] = s_data.reading_4;
        rd[5] = s_data.reading_5;
        rd[6] = s_data.reading_6;
        rd[7] = s_data.reading_7;
    end

    // Extremes over the sensors in use.
    always_comb begin
        max_next = rd[0];
        min_next = rd[0];
        for (int s = 1; s < SENSOR_COUNT; s++) begin
            if (rd[s] > max_next) max_next = rd[s];
            if (rd[s] < min_next) min_next = rd[s];
        end
    end

    assign s_ready  = !valid_reg || take;
    assign st_valid = valid_reg;
    assign st_max   = max_reg;
    assign st_min   = min_reg;

    // Stage register; a new transfer loads while the old item leaves.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            max_reg <= max_next;
            min_reg <= min_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/ser_rank_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Rank cell
// Holds one position of the descending maxima list and the ascending
// minima list, and one stage of the report shift chain.
// ----------------------------------------------------------------------------
module ser_rank_cell
    import ser_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire ser_ctrl_t  ctrl,
    input  wire ser_link_t  left,
    output ser_link_t       link,
    input  wire ser_rep_t   rep_in,
    output ser_rep_t        rep_out
);

    logic              valid_reg;
    logic              valid_next;
    logic signed [7:0] hi_reg;
    logic signed [7:0] hi_next;
    logic signed [7:0] lo_reg;
    logic signed [7:0] lo_next;
    ser_rep_t          rep_reg;
    ser_rep_t          rep_next;
    logic              take_hi;
    logic              take_lo;
    logic              valid_ins;
    logic signed [7:0] hi_ins;
    logic signed [7:0] lo_ins;

    // The new value lands here when this entry is empty or ranks below it.
    assign take_hi = !valid_reg || (ctrl.new_hi > hi_reg);
    assign take_lo = !valid_reg || (ctrl.new_lo < lo_reg);

    // Entry after insertion: shift in from the left, take the new value, or hold.
    always_comb begin
        valid_ins = valid_reg | left.valid;
        if (left.take_hi) begin
            hi_ins = left.hi;
        end else if (take_hi) begin
            hi_ins = ctrl.new_hi;
        end else begin
            hi_ins = hi_reg;
        end
        if (left.take_lo) begin
            lo_ins = left.lo;
        end else if (take_lo) begin
            lo_ins = ctrl.new_lo;
        end else begin
            lo_ins = lo_reg;
        end
    end

    always_comb begin
        valid_next = valid_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        rep_next   = rep_reg;
        if (ctrl.insert) begin
            valid_next = valid_ins;
            hi_next    = hi_ins;
            lo_next    = lo_ins;
        end
        // A period end copies the finished entry to the report chain and empties it.
        if (ctrl.snap) begin
            valid_next  = 1'b0;
            rep_next.hi = valid_ins ? hi_ins : 8'sd0;
            rep_next.lo = valid_ins ? lo_ins : 8'sd0;
        end else if (ctrl.shift) begin
            rep_next = rep_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        hi_reg  <= hi_next;
        lo_reg  <= lo_next;
        rep_reg <= rep_next;
    end

    assign link.valid   = valid_reg;
    assign link.hi      = hi_reg;
    assign link.lo      = lo_reg;
    assign link.take_hi = take_hi;
    assign link.take_lo = take_lo;
    assign rep_out      = rep_reg;

endmodule
`default_nettype wire

// File: rtl/sensor_extremes_reporter_core.sv
// An input transfer is held in the stage register until the rank cells take
// it; the first report row shows in the cycle after the period's last minute.
// Throughput: one minute per cycle. A report drains RANK_COUNT + 1 rows, one
// per cycle with m_ready high; a minute ending the next period waits for it.
// Reset (synchronous, aresetn low) empties all lists, spreads and counters and
// sets minutes_per_interval to 10.
`default_nettype none
// ----------------------------------------------------------------------------
// Sensor extremes reporter
// Tracks ranked minute maxima and minima and the widest interval spread,
// and emits a report at the end of each period.
// ----------------------------------------------------------------------------
module sensor_extremes_reporter_core
    import ser_pkg::*;
#(
    parameter int SENSOR_COUNT   = SENSOR_COUNT_DEF,
    parameter int RANK_COUNT     = RANK_COUNT_DEF,
    parameter int INTERVAL_COUNT = INTERVAL_COUNT_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_wr_en,
    input  wire logic [7:0] cfg_wr_data,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire ser_in_t    s_data,
    output logic            m_valid,
    input  wire logic       m_ready,
    output ser_out_t        m_data
);

    localparam int RW = $clog2(RANK_COUNT + 1);
    localparam int IW = (INTERVAL_COUNT > 1) ? $clog2(INTERVAL_COUNT) : 1;

    logic              st_valid;
    logic signed [7:0] st_max;
    logic signed [7:0] st_min;
    logic              take;

    logic [7:0]        mpi_reg;
    logic [7:0]        len_eff;
    logic [7:0]        minute_reg;
    logic [7:0]        minute_next;
    logic [IW-1:0]     int_idx_reg;
    logic [IW-1:0]     int_idx_next;
    logic [7:0]        cur_spread_reg;
    logic [7:0]        cur_spread_next;
    logic [IW-1:0]     best_idx_reg;
    logic [IW-1:0]     best_idx_next;
    logic [7:0]        best_val_reg;
    logic [7:0]        best_val_next;
    logic [IW-1:0]     rep_idx_reg;
    logic [IW-1:0]     rep_idx_next;
    logic [7:0]        rep_spread_reg;
    logic [7:0]        rep_spread_next;
    logic              busy_reg;
    logic              busy_next;
    logic [RW-1:0]     row_reg;
    logic [RW-1:0]     row_next;

    logic [8:0]        diff;
    logic [7:0]        spread;
    logic [7:0]        spread_max;
    logic [8:0]        minute_sum;
    logic              end_int;
    logic              last_int;
    logic              trig;
    logic              new_best;
    logic              out_xfer;
    logic              last_row;

    ser_ctrl_t         ctrl;
    ser_link_t         links [RANK_COUNT+1];
    ser_rep_t          reps  [RANK_COUNT+1];

    // Minute extremes stage.
    ser_minmax #(
        .SENSOR_COUNT (SENSOR_COUNT)
    ) u_minmax (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .take     (take),
        .st_valid (st_valid),
        .st_max   (st_max),
        .st_min   (st_min)
    );

    // Interval bookkeeping for the minute waiting in the stage register.
    assign len_eff    = (mpi_reg == 8'd0) ? 8'd1 : mpi_reg;
    assign diff       = {st_max[7], st_max} - {st_min[7], st_min};
    assign spread     = diff[7:0];
    assign spread_max = (spread > cur_spread_reg) ? spread : cur_spread_reg;
    assign minute_sum = {1'b0, minute_reg} + 9'd1;
    assign end_int    = minute_sum >= {1'b0, len_eff};
    assign last_int   = int_idx_reg == IW'(INTERVAL_COUNT - 1);
    assign trig       = end_int && last_int;
    assign new_best   = spread_max > best_val_reg;
    assign take       = st_valid && (!trig || !busy_reg);
    assign out_xfer   = m_valid && m_ready;
    assign last_row   = row_reg == RW'(RANK_COUNT);

    always_comb begin
        minute_next     = minute_reg;
        int_idx_next    = int_idx_reg;
        cur_spread_next = cur_spread_reg;
        best_idx_next   = best_idx_reg;
        best_val_next   = best_val_reg;
        rep_idx_next    = rep_idx_reg;
        rep_spread_next = rep_spread_reg;
        if (take) begin
            cur_spread_next = spread_max;
            minute_next     = minute_sum[7:0];
            if (end_int) begin
                minute_next     = 8'd0;
                cur_spread_next = 8'd0;
                int_idx_next    = int_idx_reg + IW'(1);
                if (new_best) begin
                    best_idx_next = int_idx_reg;
                    best_val_next = spread_max;
                end
            end
            // Period end: latch the widest interval and start over.
            if (trig) begin
                rep_idx_next    = new_best ? int_idx_reg : best_idx_reg;
                rep_spread_next = new_best ? spread_max : best_val_reg;
                int_idx_next    = '0;
                best_idx_next   = '0;
                best_val_next   = 8'd0;
            end
        end
    end

    // Report row sequencing.
    always_comb begin
        busy_next = busy_reg;
        row_next  = row_reg;
        if (take && trig) begin
            busy_next = 1'b1;
            row_next  = '0;
        end else if (out_xfer) begin
            if (last_row) begin
                busy_next = 1'b0;
            end else begin
                row_next = row_reg + RW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mpi_reg        <= MPI_RESET;
            minute_reg     <= 8'd0;
            int_idx_reg    <= '0;
            cur_spread_reg <= 8'd0;
            best_idx_reg   <= '0;
            best_val_reg   <= 8'd0;
            busy_reg       <= 1'b0;
            row_reg        <= '0;
        end else begin
            if (cfg_wr_en) begin
                mpi_reg <= cfg_wr_data;
            end
            minute_reg     <= minute_next;
            int_idx_reg    <= int_idx_next;
            cur_spread_reg <= cur_spread_next;
            best_idx_reg   <= best_idx_next;
            best_val_reg   <= best_val_next;
            busy_reg       <= busy_next;
            row_reg        <= row_next;
        end
        rep_idx_reg    <= rep_idx_next;
        rep_spread_reg <= rep_spread_next;
    end

    // Broadcast to the rank cells.
    assign ctrl.insert = take;
    assign ctrl.snap   = take && trig;
    assign ctrl.shift  = out_xfer && !last_row;
    assign ctrl.new_hi = st_max;
    assign ctrl.new_lo = st_min;

    // Ends of the cell row: the head always counts as filled and never shifts.
    assign links[0].valid   = 1'b1;
    assign links[0].hi      = 8'sd0;
    assign links[0].lo      = 8'sd0;
    assign links[0].take_hi = 1'b0;
    assign links[0].take_lo = 1'b0;
    assign reps[RANK_COUNT].hi = 8'sd0;
    assign reps[RANK_COUNT].lo = 8'sd0;

    for (genvar i = 0; i < RANK_COUNT; i++) begin : g_cell
        ser_rank_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (ctrl),
            .left    (links[i]),
            .link    (links[i+1]),
            .rep_in  (reps[i+1]),
            .rep_out (reps[i])
        );
    end

    // Output row from the head of the report chain or the interval latch.
    assign m_valid = busy_reg;
    always_comb begin
        m_data = '0;
        if (last_row) begin
            m_data.record_kind     = KIND_WIDEST;
            m_data.widest_interval = 3'(rep_idx_reg);
            m_data.widest_spread   = rep_spread_reg;
            m_data.last_of_report  = 1'b1;
        end else begin
            m_data.record_kind  = KIND_RANK;
            m_data.rank         = 3'(row_reg);
            m_data.high_reading = reps[0].hi;
            m_data.low_reading  = reps[0].lo;
        end
    end

endmodule
`default_nettype wire

// File: rtl/ser_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sensor extremes reporter checker
// Port-level checks on the report channel, bound to the top level.
// ----------------------------------------------------------------------------
module ser_checker
    import ser_pkg::*;
(
    input wire logic     aclk,
    input wire logic     aresetn,
    input wire logic     m_valid,
    input wire logic     m_ready,
    input wire ser_out_t m_data
);

    // A stalled row holds its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("report row changed while stalled");

    // Only the widest interval row closes a report.
    a_last_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.last_of_report == m_data.record_kind))
        else $error("last_of_report does not match record kind");

    // A rank row transfer is always followed by another row.
    a_rank_cont: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && (m_data.record_kind == KIND_RANK) |=> m_valid)
        else $error("report ended after a rank row");

    // After the final row of a report the channel goes quiet.
    a_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_data.last_of_report |=> !m_valid)
        else $error("row presented right after a report end");

    // Reset leaves no row pending.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("row presented after reset");

endmodule

bind sensor_extremes_reporter_core ser_checker u_ser_checker (.*);
`default_nettype wire

// File: tb/sensor_extremes_reporter_core_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sensor extremes reporter testbench
// Drives one-minute sensor readings into the core and checks every report row
// against a predictor that tracks the ranked extremes and interval spreads.
// The interval length is changed between phases while the core is idle, and
// both the sender and the receiver pause at random.
// ----------------------------------------------------------------------------
module sensor_extremes_reporter_core_tb;
    import ser_pkg::*;

    localparam int RANKS     = RANK_COUNT_DEF;
    localparam int INTERVALS = INTERVAL_COUNT_DEF;

    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       cfg_wr_en   = 1'b0;
    logic [7:0] cfg_wr_data = '0;
    logic       s_valid     = 1'b0;
    logic       s_ready;
    ser_in_t    s_data      = '0;
    logic       m_valid;
    logic       m_ready     = 1'b0;
    ser_out_t   m_data;

    // Minutes waiting to be sent, and report rows waiting to arrive.
    ser_in_t  minute_queue[$];
    ser_out_t expected_rows[$];
    int       err_count = 0;
    int       row_count = 0;

    // Predictor state: ranked lists (0 = maxima, 1 = minima) and spreads.
    int rank_lists[2][RANKS];
    int rank_fill = 0;
    int interval_spread[INTERVALS];
    int minute_count = 0;
    int interval_idx = 0;
    int interval_len = MPI_RESET;

    // Sender and receiver pacing.
    int gap_left  = 0;
    int calm_in   = 0;
    int stall_left = 0;
    int calm_out  = 0;

    sensor_extremes_reporter_core uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    task automatic note_mismatch(string msg);
        err_count++;
        $display("mismatch: %s", msg);
    endtask

    task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
        if (got !== want) begin
            note_mismatch($sformatf("row %0d %s got %h want %h", row_count, name, got, want));
        end
    endtask

    // Appends a minute to the tail of the pending queue.
    task automatic queue_minute(ser_in_t m);
        minute_queue.insert(minute_queue.size(), m);
    endtask

    // Mostly short pauses, now and then a long one.
    function automatic int idle_length();
        int r;
        r = $urandom_range(99, 0);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(30, 8);
    endfunction

    // A minute whose readings all equal fill, except one high and one low.
    function automatic ser_in_t spread_minute(int hi_v, int lo_v, int hi_pos, int lo_pos,
                                              int fill);
        ser_in_t m;
        for (int i = 0; i < 8; i++) begin
            m[63-8*i -: 8] = fill[7:0];
        end
        m[63-8*hi_pos -: 8] = hi_v[7:0];
        m[63-8*lo_pos -: 8] = lo_v[7:0];
        return m;
    endfunction

    // Random minute: mostly in the sensor range, some raw bytes, some flat
    // minutes and some drawn from a few values so that duplicates show up.
    function automatic ser_in_t make_random_minute();
        ser_in_t m;
        int style;
        int v;
        style = $urandom_range(9, 0);
        v = $urandom_range(170, 0) - 70;
        for (int i = 0; i < 8; i++) begin
            case (style)
                7: m[63-8*i -: 8] = 8'($urandom_range(255, 0));
                8: m[63-8*i -: 8] = v[7:0];
                9: begin
                    case ($urandom_range(3, 0))
                        0: m[63-8*i -: 8] = -8'sd70;
                        1: m[63-8*i -: 8] = 8'sd0;
                        2: m[63-8*i -: 8] = 8'sd25;
                        default: m[63-8*i -: 8] = 8'sd100;
                    endcase
                end
                default: begin
                    v = $urandom_range(170, 0) - 70;
                    m[63-8*i -: 8] = v[7:0];
                end
            endcase
        end
        return m;
    endfunction

    // Fold one accepted minute into the predictor; queue a report at the end
    // of the period.
    task automatic absorb_minute(ser_in_t m);
        int mx;
        int mn;
        int r;
        int v;
        int pos;
        int len;
        int best;
        int best_v;
        bit found;
        ser_out_t row;
        mx = $signed(m[63:56]);
        mn = mx;
        for (int s = 1; s < 8; s++) begin
            r = $signed(m[63-8*s -: 8]);
            if (r > mx) mx = r;
            if (r < mn) mn = r;
        end

        // Sorted insertion; an entry equal to an existing one goes after it.
        for (int w = 0; w < 2; w++) begin
            v = (w == 0) ? mx : mn;
            pos = rank_fill;
            found = 1'b0;
            for (int i = 0; i < rank_fill; i++) begin
                if (!found && ((w == 0) ? (v > rank_lists[w][i]) : (v < rank_lists[w][i])))
                begin
                    pos = i;
                    found = 1'b1;
                end
            end
            if (pos < RANKS) begin
                for (int i = (rank_fill < RANKS ? rank_fill : RANKS - 1); i > pos; i--) begin
                    rank_lists[w][i] = rank_lists[w][i-1];
                end
                rank_lists[w][pos] = v;
            end
        end
        if (rank_fill < RANKS) rank_fill++;

        if (interval_idx < INTERVALS && (mx - mn) > interval_spread[interval_idx]) begin
            interval_spread[interval_idx] = mx - mn;
        end

        // A length of zero behaves as one minute per interval.
        len = (interval_len == 0) ? 1 : interval_len;
        minute_count++;
        if (minute_count < len) return;
        minute_count = 0;
        interval_idx++;
        if (interval_idx < INTERVALS) return;

        for (int k = 0; k < RANKS; k++) begin
            row = '0;
            row.record_kind  = KIND_RANK;
            row.rank         = 3'(k);
            row.high_reading = (k < rank_fill) ? 8'(rank_lists[0][k]) : 8'sd0;
            row.low_reading  = (k < rank_fill) ? 8'(rank_lists[1][k]) : 8'sd0;
            expected_rows.insert(expected_rows.size(), row);
        end
        best = 0;
        best_v = 0;
        for (int k = 0; k < INTERVALS; k++) begin
            if (interval_spread[k] > best_v) begin
                best_v = interval_spread[k];
                best = k;
            end
        end
        row = '0;
        row.record_kind     = KIND_WIDEST;
        row.widest_interval = 3'(best);
        row.widest_spread   = 8'(best_v);
        row.last_of_report  = 1'b1;
        expected_rows.insert(expected_rows.size(), row);

        // The period is over, so every store starts again.
        for (int k = 0; k < RANKS; k++) begin
            rank_lists[0][k] = 0;
            rank_lists[1][k] = 0;
        end
        for (int k = 0; k < INTERVALS; k++) begin
            interval_spread[k] = 0;
        end
        rank_fill = 0;
        minute_count = 0;
        interval_idx = 0;
    endtask

    // Input driver: presents queued minutes, with random gaps between them.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            gap_left <= 0;
        end else begin
            if (s_valid && s_ready) begin
                absorb_minute(s_data);
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_valid <= 1'b0;
                end else if (minute_queue.size() > 0) begin
                    s_data <= minute_queue.pop_front();
                    s_valid <= 1'b1;
                    if (calm_in > 0) begin
                        calm_in--;
                        gap_left <= 0;
                    end else begin
                        if ($urandom_range(19, 0) == 0) calm_in = $urandom_range(40, 15);
                        gap_left <= idle_length();
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks each transfer against the oldest expected row
    // and stalls the result channel at random.
    always @(posedge aclk) begin : result_monitor
        ser_out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_rows.size() == 0) begin
                    note_mismatch($sformatf("unexpected row %0d: %h", row_count, m_data));
                end else begin
                    want = expected_rows.pop_front();
                    check_field("record_kind", 8'(m_data.record_kind), 8'(want.record_kind));
                    check_field("rank", 8'(m_data.rank), 8'(want.rank));
                    check_field("high_reading", m_data.high_reading, want.high_reading);
                    check_field("low_reading", m_data.low_reading, want.low_reading);
                    check_field("widest_interval", 8'(m_data.widest_interval),
                                8'(want.widest_interval));
                    check_field("widest_spread", m_data.widest_spread, want.widest_spread);
                    check_field("last_of_report", 8'(m_data.last_of_report),
                                8'(want.last_of_report));
                end
                row_count++;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (calm_out > 0) begin
                    calm_out--;
                end else if ($urandom_range(49, 0) == 0) begin
                    calm_out = $urandom_range(60, 20);
                end else if ($urandom_range(3, 0) == 0) begin
                    stall_left = idle_length();
                end
            end
        end
    end

    // Waits until every queued minute is taken and every row has arrived,
    // then lets the pipeline settle. The sender is checked between edges so
    // that the driver's updates for the last edge have landed.
    task automatic wait_drained();
        do @(negedge aclk); while (minute_queue.size() != 0 || s_valid);
        while (expected_rows.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_interval_len(int v);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= 8'(v);
        interval_len = v & 8'hFF;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Stimulus: directed periods first, then random phases.
    initial begin : stimulus
        int sent;
        int len;
        int cnt;
        int pick;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // One-minute intervals. First a period with no spread at all, so the
        // widest row falls back to interval zero; duplicates fill the ranks.
        write_interval_len(1);
        queue_minute(spread_minute(0, 0, 0, 1, 0));
        queue_minute(spread_minute(-70, -70, 0, 1, -70));
        queue_minute(spread_minute(100, 100, 0, 1, 100));
        queue_minute(spread_minute(-128, -128, 0, 1, -128));
        queue_minute(spread_minute(127, 127, 0, 1, 127));
        queue_minute(spread_minute(0, 0, 0, 1, 0));
        // Full byte range and tied spreads; the earliest interval must win.
        queue_minute(spread_minute(127, -128, 0, 7, 5));
        queue_minute(spread_minute(100, -70, 7, 0, 0));
        queue_minute(spread_minute(127, -128, 3, 4, -1));
        queue_minute(spread_minute(1, 0, 2, 6, 0));
        queue_minute(spread_minute(50, -50, 5, 2, 20));
        queue_minute(spread_minute(100, -70, 1, 6, 30));
        wait_drained();

        // A zero length behaves as one minute per interval.
        write_interval_len(0);
        queue_minute(spread_minute(-1, -128, 4, 3, -64));
        queue_minute(spread_minute(127, 126, 6, 5, 126));
        queue_minute(spread_minute(-128, -128, 0, 1, -128));
        queue_minute(spread_minute(85, -69, 2, 3, 7));
        queue_minute(spread_minute(100, 100, 0, 1, 100));
        queue_minute(spread_minute(0, -1, 7, 6, 0));
        wait_drained();

        // Longest length, then lowered mid-interval: the open interval closes
        // on the next minute since its count already passes the new length.
        write_interval_len(255);
        queue_minute(spread_minute(90, -60, 0, 7, 10));
        queue_minute(spread_minute(20, -20, 3, 4, 0));
        wait_drained();
        write_interval_len(1);
        queue_minute(spread_minute(64, -64, 1, 2, 8));
        queue_minute(spread_minute(-2, -3, 5, 6, -2));
        queue_minute(spread_minute(110, -100, 0, 1, 5));
        queue_minute(spread_minute(32, 16, 2, 7, 20));
        queue_minute(spread_minute(-65, -70, 3, 0, -66));
        wait_drained();

        // Random phases, most of them whole periods at short lengths.
        sent = 0;
        while (sent < 345) begin
            pick = $urandom_range(9, 0);
            if (pick == 0) begin
                len = 255;
                cnt = $urandom_range(12, 1);
            end else if (pick == 1) begin
                len = 0;
                cnt = 6 * $urandom_range(3, 1);
            end else if (pick < 7) begin
                len = $urandom_range(4, 1);
                cnt = 6 * len * $urandom_range(2, 1);
            end else begin
                len = $urandom_range(12, 5);
                cnt = 6 * len;
            end
            if (pick != 0 && $urandom_range(3, 0) == 0) cnt += $urandom_range(7, 1);
            write_interval_len(len);
            for (int i = 0; i < cnt; i++) begin
                queue_minute(make_random_minute());
            end
            wait_drained();
            sent += cnt;
        end

        repeat (20) @(posedge aclk);
        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
`default_nettype wire
